@@ hw/rtl/tods_pkg.sv @@
// tods_pkg: shared types and constants for the time-of-day sync sequencer.
// Used by tods_cfg_regs, tods_core and time_of_day_sync_sequencer_top.
// No dependencies.
`default_nettype none

package tods_pkg;

    // Sequencer states; code seven is never entered and acts as start
    typedef enum logic [2:0] {
        ST_START     = 3'd0,
        ST_DELAY     = 3'd1,
        ST_AWAIT_PPS = 3'd2,
        ST_AWAIT_TOD = 3'd3,
        ST_PAUSE     = 3'd4,
        ST_SYNCED    = 3'd5,
        ST_RESYNC    = 3'd6
    } t_seq_state;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STARTUP_PAUSE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PPS_TMO = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_NEXT_PPS_TMO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_NET_REPLY     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SAT_REPLY     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_RETRY_PAUSE   = 3'd6;

    // Source modes
    localparam logic SRC_NET = 1'b0;
    localparam logic SRC_SAT = 1'b1;

    // Input actions
    localparam logic ACT_POLL   = 1'b0;
    localparam logic ACT_RESYNC = 1'b1;

    // Register reset values
    localparam logic [31:0] RST_STARTUP_PAUSE = 32'd4000000;
    localparam logic [31:0] RST_FIRST_PPS_TMO = 32'd3100000;
    localparam logic [31:0] RST_NEXT_PPS_TMO  = 32'd1000000;
    localparam logic [31:0] RST_NET_REPLY     = 32'd100000;
    localparam logic [31:0] RST_SAT_REPLY     = 32'd1100000;
    localparam logic [31:0] RST_RETRY_PAUSE   = 32'd8000000;

    // NTP era offset (1900 to 1970) and late-marker threshold (quarter second)
    localparam logic [31:0] ERA_OFFSET = 32'd2208988800;
    localparam logic [31:0] LATE_LIMIT = 32'h4000_0000;

    typedef struct packed {
        logic        source_mode;
        logic [31:0] startup_pause_us;
        logic [31:0] first_pps_timeout_us;
        logic [31:0] next_pps_timeout_us;
        logic [31:0] net_reply_limit_us;
        logic [31:0] sat_reply_limit_us;
        logic [31:0] retry_pause_us;
    } t_cfg;

    typedef struct packed {
        logic        action;
        logic [31:0] time_us;
        logic        pps_valid;
        logic        pps_toggle;
        logic        tod_arrived;
        logic [31:0] tod_seconds;
        logic [31:0] tod_fraction;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  state_now;
        logic        send_query;
        logic        flush_receiver;
        logic        seconds_write;
        logic [31:0] seconds_value;
        logic        warn_missing_pps;
        logic        pps_resumed;
        logic        warn_no_response;
        logic        warn_late_marker;
        logic        warn_lost_pps;
    } t_out_item;

endpackage

`default_nettype wire

@@ hw/rtl/tods_cfg_regs.sv @@
// tods_cfg_regs: configuration register file of the sync sequencer.
// Depends on tods_pkg for register indexes, reset values and t_cfg.
`default_nettype none

module tods_cfg_regs
    import tods_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [CFG_IDX_W-1:0] i_wr_index,
    input  wire logic [31:0]          i_wr_data,
    output t_cfg                      o_cfg
);

    t_cfg r_cfg;

    // Register writes; indexes past the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_mode          <= SRC_NET;
            r_cfg.startup_pause_us     <= RST_STARTUP_PAUSE;
            r_cfg.first_pps_timeout_us <= RST_FIRST_PPS_TMO;
            r_cfg.next_pps_timeout_us  <= RST_NEXT_PPS_TMO;
            r_cfg.net_reply_limit_us   <= RST_NET_REPLY;
            r_cfg.sat_reply_limit_us   <= RST_SAT_REPLY;
            r_cfg.retry_pause_us       <= RST_RETRY_PAUSE;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                CFG_SOURCE_MODE:   r_cfg.source_mode          <= i_wr_data[0];
                CFG_STARTUP_PAUSE: r_cfg.startup_pause_us     <= i_wr_data;
                CFG_FIRST_PPS_TMO: r_cfg.first_pps_timeout_us <= i_wr_data;
                CFG_NEXT_PPS_TMO:  r_cfg.next_pps_timeout_us  <= i_wr_data;
                CFG_NET_REPLY:     r_cfg.net_reply_limit_us   <= i_wr_data;
                CFG_SAT_REPLY:     r_cfg.sat_reply_limit_us   <= i_wr_data;
                CFG_RETRY_PAUSE:   r_cfg.retry_pause_us       <= i_wr_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ hw/rtl/tods_core.sv @@
// tods_core: sequencer state and the single-pass step logic for one item.
// Depends on tods_pkg; fed from the top level's input register.
`default_nettype none

module tods_core
    import tods_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    t_seq_state  r_state,   n_state;
    logic [31:0] r_mark,    n_mark;
    logic        r_prev_tog, n_prev_tog;
    logic        r_seen,    n_seen;
    logic        r_later,   n_later;
    logic        r_missing, n_missing;

    logic        prev_eff;
    logic [31:0] elapsed;
    logic [31:0] pps_limit;
    logic [31:0] reply_limit;
    logic        pps_edge;
    logic        pps_tmo;
    logic        reply_tmo;
    logic        tod_ok;
    logic        delay_done;
    logic        pause_done;

    // Shared conditions; the first poll compares the toggle with itself
    assign prev_eff    = r_seen ? r_prev_tog : i_item.pps_toggle;
    assign elapsed     = i_item.time_us - r_mark;
    assign pps_limit   = r_later ? i_cfg.next_pps_timeout_us : i_cfg.first_pps_timeout_us;
    assign reply_limit = (i_cfg.source_mode == SRC_SAT) ? i_cfg.sat_reply_limit_us
                                                        : i_cfg.net_reply_limit_us;
    assign pps_edge    = i_item.pps_valid && (i_item.pps_toggle != prev_eff);
    assign pps_tmo     = elapsed > pps_limit;
    assign reply_tmo   = elapsed > reply_limit;
    assign tod_ok      = i_item.tod_arrived && (i_item.tod_seconds != 32'd0)
                         && ((i_cfg.source_mode == SRC_NET) || i_item.pps_valid);
    assign delay_done  = elapsed > i_cfg.startup_pause_us;
    assign pause_done  = elapsed > i_cfg.retry_pause_us;

    // Next state and sequencer variables
    always_comb begin
        n_state    = r_state;
        n_mark     = r_mark;
        n_prev_tog = r_prev_tog;
        n_seen     = r_seen;
        n_later    = r_later;
        n_missing  = r_missing;
        if (i_item.action == ACT_RESYNC) begin
            n_state = ST_RESYNC;
        end else begin
            n_prev_tog = i_item.pps_toggle;
            n_seen     = 1'b1;
            unique case (r_state)
                ST_DELAY: begin
                    if (delay_done) begin
                        n_mark  = i_item.time_us;
                        n_state = ST_AWAIT_PPS;
                    end
                end
                ST_RESYNC: begin
                    n_missing = 1'b0;
                    n_mark    = i_item.time_us;
                    n_state   = ST_AWAIT_PPS;
                end
                ST_AWAIT_PPS: begin
                    if (pps_edge) begin
                        n_later = 1'b1;
                        n_mark  = i_item.time_us;
                        if (r_missing) begin
                            n_missing = 1'b0;
                        end else begin
                            n_state = ST_AWAIT_TOD;
                        end
                    end else if (pps_tmo) begin
                        n_later   = 1'b1;
                        n_mark    = i_item.time_us;
                        n_missing = 1'b1;
                    end
                end
                ST_AWAIT_TOD: begin
                    if (tod_ok) begin
                        n_state = ST_SYNCED;
                    end else if (reply_tmo) begin
                        // pause is timed from the query, mark kept
                        n_state = ST_PAUSE;
                    end
                end
                ST_PAUSE: begin
                    if (pause_done) begin
                        n_mark  = i_item.time_us;
                        n_state = ST_AWAIT_PPS;
                    end
                end
                ST_SYNCED: begin
                    if (!i_item.pps_valid) begin
                        n_state = ST_RESYNC;
                    end
                end
                default: begin
                    // start, and the unused code
                    n_mark  = i_item.time_us;
                    n_state = ST_DELAY;
                end
            endcase
        end
    end

    // Result flags for this item
    always_comb begin
        o_result           = '0;
        o_result.state_now = n_state;
        if (i_item.action == ACT_POLL) begin
            unique case (r_state)
                ST_DELAY, ST_RESYNC, ST_PAUSE: ;
                ST_AWAIT_PPS: begin
                    if (pps_edge) begin
                        if (r_missing) begin
                            o_result.pps_resumed = 1'b1;
                        end else if (i_cfg.source_mode == SRC_SAT) begin
                            o_result.flush_receiver = 1'b1;
                        end else begin
                            o_result.send_query = 1'b1;
                        end
                    end else if (pps_tmo && !r_missing) begin
                        o_result.warn_missing_pps = 1'b1;
                    end
                end
                ST_AWAIT_TOD: begin
                    if (tod_ok) begin
                        o_result.seconds_write    = 1'b1;
                        o_result.seconds_value    = i_item.tod_seconds + ERA_OFFSET;
                        o_result.warn_late_marker = i_item.tod_fraction > LATE_LIMIT;
                    end else if (reply_tmo) begin
                        o_result.warn_no_response = 1'b1;
                    end
                end
                ST_SYNCED: begin
                    o_result.warn_lost_pps = !i_item.pps_valid;
                end
                default: begin
                    o_result.send_query = (i_cfg.source_mode == SRC_NET);
                end
            endcase
        end
    end

    // State registers advance once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_START;
            r_mark     <= '0;
            r_prev_tog <= 1'b0;
            r_seen     <= 1'b0;
            r_later    <= 1'b0;
            r_missing  <= 1'b0;
        end else if (i_step) begin
            r_state    <= n_state;
            r_mark     <= n_mark;
            r_prev_tog <= n_prev_tog;
            r_seen     <= n_seen;
            r_later    <= n_later;
            r_missing  <= n_missing;
        end
    end

    // A resync request always lands in the resync state
    a_resync_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_item.action == ACT_RESYNC) |=> r_state == ST_RESYNC)
        else $error("resync request did not enter resync state");

    // A seconds load is only issued on the way into synced
    a_load_synced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.seconds_write |=> r_state == ST_SYNCED)
        else $error("seconds load without entering synced");

    // Flush only in satellite mode, query and flush never together
    a_flush_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.flush_receiver |->
            (i_cfg.source_mode == SRC_SAT) && !o_result.send_query)
        else $error("flush issued outside satellite mode");

    // Any poll marks the toggle history as seeded
    a_seen_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && (i_item.action == ACT_POLL) |=> r_seen)
        else $error("poll did not seed toggle history");

endmodule

`default_nettype wire

@@ hw/rtl/time_of_day_sync_sequencer_top.sv @@
// time_of_day_sync_sequencer_top: input register, sequencer core, result register.
// Depends on tods_pkg, tods_cfg_regs and tods_core.
//
//  channel | direction | handshake                 | payload
//  --------+-----------+---------------------------+-------------------------------
//  in      | to block  | i_in_valid / o_in_stall   | i_action .. i_tod_fraction
//  out     | from block| o_out_valid / i_out_stall | o_state_now .. o_warn_lost_pps
//  cfg     | to block  | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while the result side is not stalled; an item passes
// through the input register, then the core's step logic into the result register.
// Synchronous active-low reset clears the valids and sequencer state, resets config.
// A stalled result holds the result register; one more item waits in the input
// register, after which o_in_stall rises. Config writes are always ready.
`default_nettype none

module time_of_day_sync_sequencer_top
    import tods_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input items
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic                 i_action,
    input  wire logic [31:0]          i_time_us,
    input  wire logic                 i_pps_valid,
    input  wire logic                 i_pps_toggle,
    input  wire logic                 i_tod_arrived,
    input  wire logic [31:0]          i_tod_seconds,
    input  wire logic [31:0]          i_tod_fraction,
    // result items
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [2:0]                o_state_now,
    output logic                      o_send_query,
    output logic                      o_flush_receiver,
    output logic                      o_seconds_write,
    output logic [31:0]               o_seconds_value,
    output logic                      o_warn_missing_pps,
    output logic                      o_pps_resumed,
    output logic                      o_warn_no_response,
    output logic                      o_warn_late_marker,
    output logic                      o_warn_lost_pps,
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]          i_cfg_data
);

    logic      r_in_vld;
    t_in_item  r_in;
    logic      r_out_vld;
    t_out_item r_out;

    t_cfg      cfg;
    t_out_item result;
    logic      out_free;
    logic      step;
    logic      in_take;

    // Handshake: core steps when the result register can take the item
    assign out_free   = !r_out_vld || !i_out_stall;
    assign step       = r_in_vld && out_free;
    assign o_in_stall = r_in_vld && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;

    tods_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (cfg)
    );

    tods_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (r_in),
        .i_cfg    (cfg),
        .o_result (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_take) begin
            r_in_vld <= 1'b1;
        end else if (step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.action       <= i_action;
            r_in.time_us      <= i_time_us;
            r_in.pps_valid    <= i_pps_valid;
            r_in.pps_toggle   <= i_pps_toggle;
            r_in.tod_arrived  <= i_tod_arrived;
            r_in.tod_seconds  <= i_tod_seconds;
            r_in.tod_fraction <= i_tod_fraction;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (step) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= result;
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_state_now        = r_out.state_now;
    assign o_send_query       = r_out.send_query;
    assign o_flush_receiver   = r_out.flush_receiver;
    assign o_seconds_write    = r_out.seconds_write;
    assign o_seconds_value    = r_out.seconds_value;
    assign o_warn_missing_pps = r_out.warn_missing_pps;
    assign o_pps_resumed      = r_out.pps_resumed;
    assign o_warn_no_response = r_out.warn_no_response;
    assign o_warn_late_marker = r_out.warn_late_marker;
    assign o_warn_lost_pps    = r_out.warn_lost_pps;

    // A step always leaves a result waiting
    a_step_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        step |=> r_out_vld)
        else $error("stepped item produced no result");

    // No step while the result register is held
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && i_out_stall |-> !step)
        else $error("result overwritten while stalled");

    // Input register drains when the output side is free and no new item is taken
    a_in_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld && out_free && !in_take |=> !r_in_vld)
        else $error("input register kept an item it had passed on");

endmodule

`default_nettype wire

@@ verif/tb_time_of_day_sync_sequencer_top.sv @@
// Testbench for time_of_day_sync_sequencer_top: drives poll and resync items, predicts each
// step of the PPS/time-of-day sequencer and checks every result field in order.
// Depends on tods_pkg and the RTL of time_of_day_sync_sequencer_top.
`default_nettype none

module tb_time_of_day_sync_sequencer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import tods_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned ITEMS_PER_SET = 275;
    localparam int unsigned DRAIN_CYCLES = 6;

    // Sequencer step predictor with its own copy of state and registers
    class tods_step_predictor;
        t_cfg        cfg;
        t_seq_state  seq_state;
        logic [31:0] mark_time;
        logic        prev_toggle;
        logic        seen_first;
        logic        later_check;
        logic        missing_reported;
        t_out_item   step_results_due[$];
        int unsigned errors, n_items, n_checked;
        int unsigned n_loads, n_late, n_missing, n_resumed, n_noresp, n_lost, n_resync;

        function new();
            cfg.source_mode          = SRC_NET;
            cfg.startup_pause_us     = RST_STARTUP_PAUSE;
            cfg.first_pps_timeout_us = RST_FIRST_PPS_TMO;
            cfg.next_pps_timeout_us  = RST_NEXT_PPS_TMO;
            cfg.net_reply_limit_us   = RST_NET_REPLY;
            cfg.sat_reply_limit_us   = RST_SAT_REPLY;
            cfg.retry_pause_us       = RST_RETRY_PAUSE;
            seq_state        = ST_START;
            mark_time        = '0;
            prev_toggle      = 1'b0;
            seen_first       = 1'b0;
            later_check      = 1'b0;
            missing_reported = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            case (idx)
                CFG_SOURCE_MODE:   cfg.source_mode = data[0];
                CFG_STARTUP_PAUSE: cfg.startup_pause_us = data;
                CFG_FIRST_PPS_TMO: cfg.first_pps_timeout_us = data;
                CFG_NEXT_PPS_TMO:  cfg.next_pps_timeout_us = data;
                CFG_NET_REPLY:     cfg.net_reply_limit_us = data;
                CFG_SAT_REPLY:     cfg.sat_reply_limit_us = data;
                CFG_RETRY_PAUSE:   cfg.retry_pause_us = data;
                default: ;
            endcase
        endfunction

        function int pending();
            return step_results_due.size();
        endfunction

        // One accepted item: advance the sequencer and queue its result
        function void note_poll_item(t_in_item it);
            t_out_item   e;
            logic [31:0] elapsed;
            logic [31:0] limit;
            e = '0;
            elapsed = it.time_us - mark_time;
            n_items++;
            if (it.action == ACT_RESYNC) begin
                seq_state = ST_RESYNC;
                n_resync++;
            end else begin
                // first poll only seeds the edge detector
                if (!seen_first) begin
                    prev_toggle = it.pps_toggle;
                    seen_first  = 1'b1;
                end
                case (seq_state)
                    ST_DELAY: begin
                        if (elapsed > cfg.startup_pause_us) begin
                            mark_time = it.time_us;
                            seq_state = ST_AWAIT_PPS;
                        end
                    end
                    ST_RESYNC: begin
                        missing_reported = 1'b0;
                        mark_time = it.time_us;
                        seq_state = ST_AWAIT_PPS;
                    end
                    ST_AWAIT_PPS: begin
                        if (it.pps_valid && it.pps_toggle != prev_toggle) begin
                            later_check = 1'b1;
                            mark_time = it.time_us;
                            if (missing_reported) begin
                                e.pps_resumed = 1'b1;
                                missing_reported = 1'b0;
                            end else begin
                                if (cfg.source_mode == SRC_SAT) e.flush_receiver = 1'b1;
                                else e.send_query = 1'b1;
                                seq_state = ST_AWAIT_TOD;
                            end
                        end else if (elapsed > (later_check ? cfg.next_pps_timeout_us
                                                            : cfg.first_pps_timeout_us)) begin
                            later_check = 1'b1;
                            mark_time = it.time_us;
                            if (!missing_reported) e.warn_missing_pps = 1'b1;
                            missing_reported = 1'b1;
                        end
                    end
                    ST_AWAIT_TOD: begin
                        limit = (cfg.source_mode == SRC_SAT) ? cfg.sat_reply_limit_us
                                                              : cfg.net_reply_limit_us;
                        if (it.tod_arrived && it.tod_seconds != 0 &&
                            (cfg.source_mode == SRC_NET || it.pps_valid)) begin
                            e.seconds_write = 1'b1;
                            e.seconds_value = it.tod_seconds + ERA_OFFSET;
                            if (it.tod_fraction > LATE_LIMIT) e.warn_late_marker = 1'b1;
                            seq_state = ST_SYNCED;
                        end else if (elapsed > limit) begin
                            // pause is timed from the query, mark_time stays
                            e.warn_no_response = 1'b1;
                            seq_state = ST_PAUSE;
                        end
                    end
                    ST_PAUSE: begin
                        if (elapsed > cfg.retry_pause_us) begin
                            mark_time = it.time_us;
                            seq_state = ST_AWAIT_PPS;
                        end
                    end
                    ST_SYNCED: begin
                        if (!it.pps_valid) begin
                            e.warn_lost_pps = 1'b1;
                            seq_state = ST_RESYNC;
                        end
                    end
                    default: begin
                        if (cfg.source_mode == SRC_NET) e.send_query = 1'b1;
                        mark_time = it.time_us;
                        seq_state = ST_DELAY;
                    end
                endcase
                prev_toggle = it.pps_toggle;
            end
            e.state_now = seq_state;
            n_loads   += e.seconds_write;
            n_late    += e.warn_late_marker;
            n_missing += e.warn_missing_pps;
            n_resumed += e.pps_resumed;
            n_noresp  += e.warn_no_response;
            n_lost    += e.warn_lost_pps;
            step_results_due.push_back(e);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch: %s", $realtime, msg);
            errors++;
        endtask

        task cmp_field(string name, logic [31:0] got_v, logic [31:0] exp_v);
            if (got_v !== exp_v)
                report_mismatch($sformatf("result %0d %s got 0x%0h expected 0x%0h",
                                          n_checked, name, got_v, exp_v));
        endtask

        // Compare one result with the oldest expected step
        task check_step_result(t_out_item got);
            t_out_item e;
            if (step_results_due.size() == 0) begin
                report_mismatch("result arrived with nothing expected");
            end else begin
                e = step_results_due.pop_front();
                cmp_field("state_now", got.state_now, e.state_now);
                cmp_field("send_query", got.send_query, e.send_query);
                cmp_field("flush_receiver", got.flush_receiver, e.flush_receiver);
                cmp_field("seconds_write", got.seconds_write, e.seconds_write);
                cmp_field("seconds_value", got.seconds_value, e.seconds_value);
                cmp_field("warn_missing_pps", got.warn_missing_pps, e.warn_missing_pps);
                cmp_field("pps_resumed", got.pps_resumed, e.pps_resumed);
                cmp_field("warn_no_response", got.warn_no_response, e.warn_no_response);
                cmp_field("warn_late_marker", got.warn_late_marker, e.warn_late_marker);
                cmp_field("warn_lost_pps", got.warn_lost_pps, e.warn_lost_pps);
                n_checked++;
            end
        endtask
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic                 i_action = 1'b0;
    logic [31:0]          i_time_us = '0;
    logic                 i_pps_valid = 1'b0;
    logic                 i_pps_toggle = 1'b0;
    logic                 i_tod_arrived = 1'b0;
    logic [31:0]          i_tod_seconds = '0;
    logic [31:0]          i_tod_fraction = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [2:0]           o_state_now;
    logic                 o_send_query;
    logic                 o_flush_receiver;
    logic                 o_seconds_write;
    logic [31:0]          o_seconds_value;
    logic                 o_warn_missing_pps;
    logic                 o_pps_resumed;
    logic                 o_warn_no_response;
    logic                 o_warn_late_marker;
    logic                 o_warn_lost_pps;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]          i_cfg_data = '0;

    tods_step_predictor sb;
    t_out_item          seen_result;
    int unsigned        cycle_count = 0;
    int unsigned        gap_pct = 0;
    int unsigned        stall_pct = 0;
    logic [31:0]        clock_us = '0;
    logic               pps_level = 1'b0;

    time_of_day_sync_sequencer_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_action           (i_action),
        .i_time_us          (i_time_us),
        .i_pps_valid        (i_pps_valid),
        .i_pps_toggle       (i_pps_toggle),
        .i_tod_arrived      (i_tod_arrived),
        .i_tod_seconds      (i_tod_seconds),
        .i_tod_fraction     (i_tod_fraction),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_state_now        (o_state_now),
        .o_send_query       (o_send_query),
        .o_flush_receiver   (o_flush_receiver),
        .o_seconds_write    (o_seconds_write),
        .o_seconds_value    (o_seconds_value),
        .o_warn_missing_pps (o_warn_missing_pps),
        .o_pps_resumed      (o_pps_resumed),
        .o_warn_no_response (o_warn_no_response),
        .o_warn_late_marker (o_warn_late_marker),
        .o_warn_lost_pps    (o_warn_lost_pps),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Receiver back-pressure
    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            seen_result.state_now        = o_state_now;
            seen_result.send_query       = o_send_query;
            seen_result.flush_receiver   = o_flush_receiver;
            seen_result.seconds_write    = o_seconds_write;
            seen_result.seconds_value    = o_seconds_value;
            seen_result.warn_missing_pps = o_warn_missing_pps;
            seen_result.pps_resumed      = o_pps_resumed;
            seen_result.warn_no_response = o_warn_no_response;
            seen_result.warn_late_marker = o_warn_late_marker;
            seen_result.warn_lost_pps    = o_warn_lost_pps;
            sb.check_step_result(seen_result);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending());
            $display("FAIL time_of_day_sync_sequencer_top");
            $finish;
        end
    end

    // Present one item, optionally after a gap, and hold it until taken
    task automatic send_poll_item(input t_in_item it);
        if ($urandom_range(99) < gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= it.action;
        i_time_us      <= it.time_us;
        i_pps_valid    <= it.pps_valid;
        i_pps_toggle   <= it.pps_toggle;
        i_tod_arrived  <= it.tod_arrived;
        i_tod_seconds  <= it.tod_seconds;
        i_tod_fraction <= it.tod_fraction;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_poll_item(it);
    endtask

    task automatic drive_step(input logic [31:0] dt, input logic act, input logic pv,
                              input logic tg, input logic arr, input logic [31:0] secs,
                              input logic [31:0] frac);
        t_in_item it;
        clock_us = clock_us + dt;
        it.action       = act;
        it.time_us      = clock_us;
        it.pps_valid    = pv;
        it.pps_toggle   = tg;
        it.tod_arrived  = arr;
        it.tod_seconds  = secs;
        it.tod_fraction = frac;
        send_poll_item(it);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
    endtask

    // Reprogram all registers once the block has drained
    task automatic configure(input logic mode, input logic [31:0] startup,
                             input logic [31:0] first_tmo, input logic [31:0] next_tmo,
                             input logic [31:0] net_lim, input logic [31:0] sat_lim,
                             input logic [31:0] retry);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        write_reg(CFG_SOURCE_MODE, {31'd0, mode});
        write_reg(CFG_STARTUP_PAUSE, startup);
        write_reg(CFG_FIRST_PPS_TMO, first_tmo);
        write_reg(CFG_NEXT_PPS_TMO, next_tmo);
        write_reg(CFG_NET_REPLY, net_lim);
        write_reg(CFG_SAT_REPLY, sat_lim);
        write_reg(CFG_RETRY_PAUSE, retry);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed polls around the timeout scale, some wild time jumps
    function automatic t_in_item rand_item(input int unsigned scale);
        t_in_item    it;
        int unsigned pick;
        logic [31:0] step;
        pick = $urandom_range(99);
        if (pick < 70) step = $urandom_range(scale / 2);
        else if (pick < 95) step = $urandom_range(scale * 2, scale / 2);
        else step = $urandom();
        clock_us = clock_us + step;
        if ($urandom_range(99) < 30) pps_level = ~pps_level;
        it.action      = ($urandom_range(99) < 3) ? ACT_RESYNC : ACT_POLL;
        it.time_us     = clock_us;
        it.pps_valid   = ($urandom_range(99) < 90);
        it.pps_toggle  = pps_level;
        it.tod_arrived = ($urandom_range(99) < ((sb.seq_state == ST_AWAIT_TOD) ? 40 : 10));
        pick = $urandom_range(99);
        if (pick < 10) it.tod_seconds = '0;
        else if (pick < 15) it.tod_seconds = '1;
        else it.tod_seconds = $urandom();
        pick = $urandom_range(99);
        if (pick < 5) it.tod_fraction = LATE_LIMIT;
        else if (pick < 10) it.tod_fraction = LATE_LIMIT + 1;
        else it.tod_fraction = $urandom();
        return it;
    endfunction

    initial begin
        int unsigned scale;
        sb = new();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        gap_pct   = 13;
        stall_pct = 57;

        // Directed walk through every state with default registers
        drive_step(0, ACT_POLL, 1, 1, 0, 0, 0);           // first poll, no edge
        drive_step(4000000, ACT_POLL, 1, 1, 0, 0, 0);     // pause not yet exceeded
        drive_step(1, ACT_POLL, 1, 0, 0, 0, 0);           // leave startup delay
        drive_step(10, ACT_POLL, 0, 1, 0, 0, 0);          // toggle with PPS invalid
        drive_step(3100000, ACT_POLL, 1, 1, 0, 0, 0);     // first missing warning
        drive_step(1000001, ACT_POLL, 1, 1, 0, 0, 0);     // missing again, no warning
        drive_step(5, ACT_POLL, 1, 0, 0, 0, 0);           // PPS resumed
        drive_step(5, ACT_POLL, 1, 1, 0, 0, 0);           // edge: query
        drive_step(5, ACT_POLL, 1, 1, 1, 0, '1);          // answer with zero seconds
        drive_step(100001, ACT_POLL, 1, 1, 0, 0, 0);      // no response
        drive_step(7899994, ACT_POLL, 1, 1, 1, 7, 0);     // pause boundary, answer ignored
        drive_step(1, ACT_POLL, 1, 1, 0, 0, 0);           // back to await PPS
        drive_step(5, ACT_POLL, 1, 0, 0, 0, 0);           // edge: query
        drive_step(5, ACT_POLL, 1, 0, 1, '1, LATE_LIMIT); // load, marker on the limit
        drive_step(5, ACT_POLL, 1, 0, 1, 1, '1);          // synced, answer ignored
        drive_step(5, ACT_POLL, 0, 0, 0, 0, 0);           // PPS lost
        drive_step(5, ACT_POLL, 1, 1, 0, 0, 0);           // resync step
        drive_step('1, ACT_RESYNC, 1, 1, 1, '1, '1);      // resync request, clock wraps
        drive_step(5, ACT_POLL, 1, 0, 0, 0, 0);
        drive_step(5, ACT_POLL, 1, 1, 0, 0, 0);           // edge: query
        drive_step(5, ACT_POLL, 1, 1, 1, 1, LATE_LIMIT + 1); // load, late marker

        // Random sets: register settings including both extremes
        for (int set_no = 0; set_no < 6; set_no++) begin
            case (set_no)
                0: begin
                    configure(SRC_NET, 200, 300, 150, 100, 250, 400);
                    scale = 300;
                end
                1: begin
                    configure(SRC_SAT, 0, 0, 0, 0, 0, 0);
                    scale = 50;
                end
                2: begin
                    configure(SRC_SAT, 1000, 2000, 800, 500, 1500, 2000);
                    scale = 1000;
                end
                3: begin
                    configure(SRC_NET, '1, '1, '1, '1, '1, '1);
                    scale = 1000;
                end
                4: begin
                    configure(SRC_SAT, '1, 32'h8000_0000, 32'h7FFF_FFFF, 1,
                              32'hFFFF_FFFE, 1);
                    scale = 1000;
                end
                default: begin
                    configure(SRC_NET, $urandom_range(3000), $urandom_range(3000),
                              $urandom_range(3000), $urandom_range(3000),
                              $urandom_range(3000), $urandom_range(3000));
                    scale = 1500;
                end
            endcase
            // idling: sender light/receiver heavy, then swapped, then none
            case (set_no / 2)
                0: begin gap_pct = 13; stall_pct = 57; end
                1: begin gap_pct = 57; stall_pct = 13; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            for (int n = 0; n < ITEMS_PER_SET; n++)
                send_poll_item(rand_item(scale));
        end

        // Drain and finish
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0) sb.report_mismatch("expected results never arrived");
        $display("%0d items, %0d results checked; loads %0d (late %0d), resync requests %0d",
                 sb.n_items, sb.n_checked, sb.n_loads, sb.n_late, sb.n_resync);
        $display("missing PPS %0d, resumed %0d, no response %0d, lost PPS %0d, mismatches %0d",
                 sb.n_missing, sb.n_resumed, sb.n_noresp, sb.n_lost, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS time_of_day_sync_sequencer_top");
        end else begin
            $display("FAIL time_of_day_sync_sequencer_top");
        end
        $finish;
    end

endmodule

`default_nettype wire
